FILE: rtl/core/cdq_pkg.sv
// Shared constants, codes and control types for the circular deque block.
package cdq_pkg;

  // Store size and derived widths
  localparam int CAPACITY = 16;
  localparam int CAP_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  // Request commands
  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_DELETE     = 3'd4,
    CMD_LIST       = 3'd5
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // Operation broadcast to every cell of the chain
  typedef enum logic [2:0] {
    OP_HOLD       = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_PULL       = 3'd3,
    OP_ROTATE     = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t                op;
    logic [CAP_W-1:0]        sel;
    logic signed [VAL_W-1:0] value;
  } cell_ctl_t;

endpackage

FILE: rtl/core/circular_deque_with_value_delete_unit.sv
// Top level of the bounded deque: command sequencer, cell chain and result register.
//
// Usage: each request on in_* carries a command and a value. Results leave on
// out_* with a status, a listed value (zero except for listing) and a last flag.
// End commands (insert or remove at either end, listing an empty store) are
// worked at once: the request is accepted and its result is loaded into the output
// register at the same edge. Remove-by-value walks the cell chain one cell per
// cycle from the head up to the first match or the tail. Listing emits one entry
// per cycle while the receiver keeps up, rotating the chain, entry_count in all, and
// leaves the order as it was. One request is worked at a time; in_ready is high
// only while the sequencer is idle and the output register is free or draining.
// When the receiver stalls, the result waits in the output register and the
// walk holds in place. Commands 6 and 7 are accepted and give no result.
// Reset (rst_n low, synchronous) empties the store; entry contents are not
// cleared, since only occupied cells are ever read.
module circular_deque_with_value_delete_unit
  import cdq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              in_command,
  input  logic signed [VAL_W-1:0] in_element_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_status,
  output logic signed [VAL_W-1:0] out_listed_value,
  output logic                    out_last_result
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_LIST = 3'b100
  } state_t;

  state_t                  st_r, st_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic signed [VAL_W-1:0] key_r;
  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic                    out_last_r;

  cell_ctl_t               ctl;
  logic signed [VAL_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]     cell_hit;

  logic                    out_free;
  logic                    accept;
  logic                    full;
  logic                    empty;
  logic [CNT_W-1:0]        cnt_m1;
  logic                    load_out;
  status_t                 res_status;
  logic signed [VAL_W-1:0] res_value;
  logic                    res_last;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (st_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign full     = (cnt_r == CNT_W'(CAPACITY));
  assign empty    = (cnt_r == '0);
  assign cnt_m1   = cnt_r - CNT_W'(1);

  // Cell chain: entry 0 is the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_v;
    logic signed [VAL_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = ctl.value;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = cell_val[i];
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end
    cdq_cell u_cell (
      .clk       (clk),
      .cell_idx  (CAP_W'(i)),
      .ctl       (ctl),
      .left_val  (left_v),
      .right_val (right_v),
      .head_val  (cell_val[0]),
      .val       (cell_val[i]),
      .hit       (cell_hit[i])
    );
  end

  // Sequence requests and drive the chain
  always_comb begin
    st_nxt     = st_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    ctl.op     = OP_HOLD;
    ctl.sel    = '0;
    ctl.value  = (st_r == S_IDLE) ? in_element_value : key_r;
    load_out   = 1'b0;
    res_status = ST_OK;
    res_value  = '0;
    res_last   = 1'b1;
    case (st_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt = '0;
          case (cmd_t'(in_command))
            CMD_PUSH_FRONT: begin
              load_out = 1'b1;
              if (full) begin
                res_status = ST_FULL;
              end else begin
                ctl.op  = OP_PUSH_FRONT;
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            CMD_PUSH_BACK: begin
              load_out = 1'b1;
              if (full) begin
                res_status = ST_FULL;
              end else begin
                ctl.op  = OP_PUSH_BACK;
                ctl.sel = cnt_r[CAP_W-1:0];
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            CMD_POP_FRONT: begin
              load_out = 1'b1;
              if (empty) begin
                res_status = ST_EMPTY;
              end else begin
                ctl.op  = OP_PULL;
                ctl.sel = '0;
                cnt_nxt = cnt_m1;
              end
            end
            CMD_POP_BACK: begin
              load_out = 1'b1;
              if (empty) res_status = ST_EMPTY;
              else       cnt_nxt    = cnt_m1;
            end
            CMD_DELETE: begin
              st_nxt = S_SCAN;
            end
            CMD_LIST: begin
              if (empty) begin
                load_out   = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                st_nxt = S_LIST;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (idx_r >= cnt_r) begin
          // walked past the tail: value absent
          if (out_free) begin
            load_out   = 1'b1;
            res_status = ST_MISSING;
            st_nxt     = S_IDLE;
          end
        end else if (cell_hit[idx_r[CAP_W-1:0]]) begin
          // close the gap at the first match
          if (out_free) begin
            load_out = 1'b1;
            ctl.op   = OP_PULL;
            ctl.sel  = idx_r[CAP_W-1:0];
            cnt_nxt  = cnt_m1;
            st_nxt   = S_IDLE;
          end
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      S_LIST: begin
        // emit the head, then rotate it to the tail
        if (out_free) begin
          load_out  = 1'b1;
          res_value = cell_val[0];
          res_last  = (idx_r == cnt_m1);
          ctl.op    = OP_ROTATE;
          ctl.sel   = cnt_m1[CAP_W-1:0];
          idx_nxt   = idx_r + CNT_W'(1);
          if (idx_r == cnt_m1) st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) key_r <= in_element_value;
    if (load_out) begin
      out_status_r <= res_status;
      out_value_r  <= res_value;
      out_last_r   <= res_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_listed_value = out_value_r;
  assign out_last_result  = out_last_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cnt_r == $past(cnt_r) || cnt_r == $past(cnt_r) + CNT_W'(1) ||
                      cnt_r == $past(cnt_r) - CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_list_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_LIST) |=> (cnt_r == $past(cnt_r)))
    else $error("listing changed the entry count");

  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_value_r == '0))
    else $error("error result carries a value");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SCAN) |-> (idx_r <= cnt_r))
    else $error("search walked past the tail");

endmodule

FILE: rtl/core/cdq_cell.sv
// One storage cell of the deque chain: holds one entry and trades it with its neighbors.
module cdq_cell
  import cdq_pkg::*;
(
  input  logic                    clk,
  input  logic [CAP_W-1:0]        cell_idx,
  input  cell_ctl_t               ctl,
  input  logic signed [VAL_W-1:0] left_val,
  input  logic signed [VAL_W-1:0] right_val,
  input  logic signed [VAL_W-1:0] head_val,
  output logic signed [VAL_W-1:0] val,
  output logic                    hit
);

  logic signed [VAL_W-1:0] val_r;
  logic signed [VAL_W-1:0] val_nxt;

  // Pick the next entry from the broadcast operation
  always_comb begin
    val_nxt = val_r;
    case (ctl.op)
      OP_HOLD:       val_nxt = val_r;
      OP_PUSH_FRONT: val_nxt = left_val;
      OP_PUSH_BACK: begin
        if (cell_idx == ctl.sel) val_nxt = ctl.value;
      end
      OP_PULL: begin
        if (cell_idx >= ctl.sel) val_nxt = right_val;
      end
      OP_ROTATE: begin
        if (cell_idx == ctl.sel) val_nxt = head_val;
        else                     val_nxt = right_val;
      end
      default: val_nxt = val_r;
    endcase
  end

  // Hold the entry
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;
  assign hit = (val_r == ctl.value);

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the bounded circular deque with delete-by-value.
`timescale 1ns / 100ps

module tb_top
  import cdq_pkg::*;
;

  // Commands that the block accepts and drops without a result
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 2 * CAPACITY + 8;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    status_t                 status;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } deque_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [2:0]              in_command = CMD_PUSH_FRONT;
  logic signed [VAL_W-1:0] in_element_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [1:0]              out_status;
  logic signed [VAL_W-1:0] out_listed_value;
  logic                    out_last_result;

  // Predicted deque contents, head first, and the results still owed
  logic signed [VAL_W-1:0] deque_contents[$];
  deque_result_t           expected_results[$];

  int error_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  circular_deque_with_value_delete_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_element_value (in_element_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_listed_value (out_listed_value),
    .out_last_result  (out_last_result)
  );

  always #5 clk = ~clk;

  // Stall the result channel at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  task automatic expect_result(input status_t status, input logic signed [VAL_W-1:0] value,
                               input logic last);
    deque_result_t r;
    r.status = status;
    r.value  = value;
    r.last   = last;
    expected_results.push_back(r);
  endtask

  // Apply one accepted request to the predicted deque and queue its results
  task automatic predict_request(input logic [2:0] cmd, input logic signed [VAL_W-1:0] value);
    int hit;
    hit = -1;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (deque_contents.size() >= CAPACITY) begin
          expect_result(ST_FULL, '0, 1'b1);
        end else begin
          if (cmd == CMD_PUSH_FRONT) deque_contents.push_front(value);
          else deque_contents.push_back(value);
          expect_result(ST_OK, '0, 1'b1);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (deque_contents.size() == 0) begin
          expect_result(ST_EMPTY, '0, 1'b1);
        end else begin
          if (cmd == CMD_POP_FRONT) void'(deque_contents.pop_front());
          else void'(deque_contents.pop_back());
          expect_result(ST_OK, '0, 1'b1);
        end
      end
      CMD_DELETE: begin
        // search from the head, drop the first equal entry only
        for (int i = 0; i < deque_contents.size(); i++) begin
          if (hit < 0 && deque_contents[i] === value) hit = i;
        end
        if (hit >= 0) begin
          deque_contents.delete(hit);
          expect_result(ST_OK, '0, 1'b1);
        end else begin
          expect_result(ST_MISSING, '0, 1'b1);
        end
      end
      CMD_LIST: begin
        if (deque_contents.size() == 0) begin
          expect_result(ST_EMPTY, '0, 1'b1);
        end else begin
          foreach (deque_contents[i]) begin
            expect_result(ST_OK, deque_contents[i], i == deque_contents.size() - 1);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Drive one request, wait for the handshake, then predict it
  task automatic send_request(input logic [2:0] cmd, input logic signed [VAL_W-1:0] value);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_element_value <= value;
    do @(posedge clk); while (!in_ready);
    predict_request(cmd, value);
  endtask

  // Mix of stored values, small values that repeat, and full-range patterns
  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(3))
      0: begin
        if (deque_contents.size() > 0) v = deque_contents[$urandom_range(deque_contents.size() - 1)];
        else v = $urandom;
      end
      1: v = $urandom_range(7);
      2: v = -$signed({1'b0, 4'($urandom_range(7))});
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    deque_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_error($sformatf("unexpected result status=%0d value=%0d last=%0b",
                               out_status, out_listed_value, out_last_result));
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status || out_listed_value !== want.value ||
            out_last_result !== want.last) begin
          report_error($sformatf(
            "expected status=%0d value=%0d last=%0b, got status=%0d value=%0d last=%0b",
            want.status, want.value, want.last, out_status, out_listed_value,
            out_last_result));
        end
      end
    end
  end

  // End the run when neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Removes, listing and search on an empty store, plus the spare commands
  task automatic test_empty_store();
    send_request(CMD_POP_FRONT, 32'sd0);
    send_request(CMD_POP_BACK, -32'sd1);
    send_request(CMD_LIST, 32'sd0);
    send_request(CMD_DELETE, 32'sd0);
    send_request(CMD_DELETE, 32'sh8000_0000);
    send_request(CMD_SPARE_6, 32'sh7FFF_FFFF);
    send_request(CMD_SPARE_7, 32'sh8000_0000);
  endtask

  // Extreme values, duplicates and first-match delete
  task automatic test_value_extremes();
    send_request(CMD_PUSH_FRONT, 32'sh7FFF_FFFF);
    send_request(CMD_PUSH_BACK, 32'sh8000_0000);
    send_request(CMD_PUSH_FRONT, 32'sd0);
    send_request(CMD_PUSH_BACK, -32'sd1);
    send_request(CMD_PUSH_BACK, 32'sd0);
    send_request(CMD_PUSH_BACK, 32'shAAAA_AAAA);
    send_request(CMD_PUSH_FRONT, 32'sh5555_5555);
    send_request(CMD_LIST, 32'sd0);
    send_request(CMD_DELETE, 32'sd0);
    send_request(CMD_DELETE, 32'sd12345);
    send_request(CMD_DELETE, 32'shAAAA_AAAA);
    send_request(CMD_LIST, -32'sd1);
    send_request(CMD_POP_BACK, 32'sd0);
    send_request(CMD_POP_FRONT, 32'sd0);
    send_request(CMD_DELETE, 32'sh8000_0000);
    send_request(CMD_LIST, 32'sd0);
  endtask

  // Fill to capacity, hit the full case at both ends, then drain to empty
  task automatic test_fill_and_drain();
    int pick;
    while (deque_contents.size() < CAPACITY) begin
      send_request($urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_value());
    end
    send_request(CMD_PUSH_FRONT, $urandom);
    send_request(CMD_PUSH_BACK, $urandom);
    send_request(CMD_LIST, $urandom);
    send_request(CMD_DELETE, deque_contents[CAPACITY-1]);
    send_request(CMD_DELETE, $urandom);
    while (deque_contents.size() > 0) begin
      pick = $urandom_range(9);
      if (pick < 3) send_request(CMD_POP_FRONT, $urandom);
      else if (pick < 6) send_request(CMD_POP_BACK, $urandom);
      else if (pick < 9) send_request(CMD_DELETE, pick_value());
      else send_request(CMD_LIST, $urandom);
    end
    send_request(CMD_POP_BACK, $urandom);
  endtask

  // Random command mix; spare commands do not count toward the total
  task automatic test_random_mix(input int count);
    int sent;
    int pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 18) send_request(CMD_PUSH_FRONT, pick_value());
      else if (pick < 36) send_request(CMD_PUSH_BACK, pick_value());
      else if (pick < 46) send_request(CMD_POP_FRONT, $urandom);
      else if (pick < 56) send_request(CMD_POP_BACK, $urandom);
      else if (pick < 78) send_request(CMD_DELETE, pick_value());
      else if (pick < 95) send_request(CMD_LIST, $urandom);
      else send_request($urandom_range(1) ? CMD_SPARE_7 : CMD_SPARE_6, $urandom);
      if (pick < 95) sent++;
    end
  endtask

  initial begin
    // hold reset, then release
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_store();
    test_value_extremes();

    // idle phases: none, sender gaps, receiver stalls, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 74; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      test_fill_and_drain();
      test_random_mix(40);
    end

    // drop valid and wait out the remaining results
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/cdq_pkg.sv
rtl/core/cdq_cell.sv
rtl/core/circular_deque_with_value_delete_unit.sv
dv/tb_top.sv
